FILE: sv/rmn_pkg.sv
package rmn_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int QUOT_W     = DATA_WIDTH + FRAC_BITS;
    localparam int STEP_W     = $clog2(QUOT_W);
    localparam int MAX_COLS   = 64;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int LEN_W      = COL_W + 1;
    localparam int ROWS_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FIRST_COL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LAST_COL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_FIRST_COL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_LAST_COL  = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_LOAD = 4'b0100,
        S_DIV  = 4'b1000
    } state_t;

    typedef struct packed {
        logic start;
        logic [DATA_WIDTH-1:0] dividend;
        logic [DATA_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [DATA_WIDTH-1:0] magnitude(input logic [DATA_WIDTH-1:0] v);
        magnitude = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

FILE: sv/rmn_ram.sv
module rmn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/rmn_div.sv
module rmn_div (
    input  logic             clk,
    input  logic             rst_n,
    input  rmn_pkg::div_req_t req,
    output rmn_pkg::div_rsp_t rsp
);

    logic                              run_reg, run_next;
    logic                              done_reg, done_next;
    logic [rmn_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [rmn_pkg::DATA_WIDTH-1:0]    rem_reg, rem_next;
    logic [rmn_pkg::DATA_WIDTH-1:0]    dvs_reg, dvs_next;
    logic [rmn_pkg::QUOT_W-1:0]        nq_reg, nq_next;
    logic [rmn_pkg::DATA_WIDTH:0]      trial;
    logic [rmn_pkg::DATA_WIDTH:0]      diff;
    logic                              ge;

    assign trial = {rem_reg, nq_reg[rmn_pkg::QUOT_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        nq_next   = nq_reg;
        if (req.start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvs_next  = req.divisor;
            nq_next   = {req.dividend, {rmn_pkg::FRAC_BITS{1'b0}}};
        end
        else if (run_reg)
        begin
            rem_next  = ge ? diff[rmn_pkg::DATA_WIDTH-1:0] : trial[rmn_pkg::DATA_WIDTH-1:0];
            nq_next   = {nq_reg[rmn_pkg::QUOT_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == rmn_pkg::STEP_W'(rmn_pkg::QUOT_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        nq_reg  <= nq_next;
    end

    assign rsp = {done_reg, nq_reg};

endmodule

FILE: sv/row_maxabs_normalize_top.sv
// Channel   Handshake              Payload
// input     start / busy           sample
// config    cfg_write              cfg_index, cfg_data
// result    result_valid (1 cycle) scaled, column, row_end, matrix_end, zero_max
//
// A sample is taken when start && !busy; a sample that does not finish a row leaves busy low.
// On row completion each element is read back from the row RAM in S_READ and S_LOAD; an
// element that passes unchanged or is zeroed is issued in S_LOAD, a scaled element in S_DIV
// once the bit-serial divider (one quotient bit per cycle over 48 bits) signals done.
// Reset clears all control state and loads the register defaults; the row RAM is not cleared.
// busy stays high from row completion until the last word of the row is issued.
// The receiver cannot stall: every result word is valid for exactly one cycle.
module row_maxabs_normalize_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [rmn_pkg::DATA_WIDTH-1:0] sample,
    input  logic                               cfg_write,
    input  logic [rmn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rmn_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               result_valid,
    output logic signed [rmn_pkg::DATA_WIDTH-1:0] scaled,
    output logic [rmn_pkg::COL_W-1:0]          column,
    output logic                               row_end,
    output logic                               matrix_end,
    output logic                               zero_max
);

    localparam int DW = rmn_pkg::DATA_WIDTH;
    localparam int CW = rmn_pkg::COL_W;
    localparam int LW = rmn_pkg::LEN_W;
    localparam int RW = rmn_pkg::ROWS_W;
    localparam int QW = rmn_pkg::QUOT_W;

    logic [LW-1:0] row_length_reg;
    logic [RW-1:0] row_count_reg;
    logic [CW-1:0] max_first_reg, max_last_reg, norm_first_reg, norm_last_reg;

    rmn_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [LW-1:0]   count_reg, count_next;
    logic [DW-1:0]   peak_reg, peak_next;
    logic [RW-1:0]   row_cnt_reg, row_cnt_next;
    logic            zero_reg, zero_next;
    logic            last_row_reg, last_row_next;
    logic            neg_reg, neg_next;

    logic            valid_reg, valid_next;
    logic [DW-1:0]   scaled_reg, scaled_next;
    logic [CW-1:0]   column_reg, column_next;
    logic            row_end_reg, row_end_next;
    logic            matrix_end_reg, matrix_end_next;
    logic            zero_out_reg, zero_out_next;

    logic            accept;
    logic [LW-1:0]   len;
    logic [DW-1:0]   sample_mag;
    logic [DW-1:0]   peak_upd;
    logic [LW-1:0]   count_now;
    logic            in_max;
    logic            in_norm;
    logic            last_k;
    logic [DW-1:0]   ram_rdata;
    logic [DW-1:0]   sat_mag;
    logic [DW-1:0]   emit_value;
    logic            emit;
    logic [QW-1:0]   lim;
    logic            div_start;

    rmn_pkg::div_req_t div_req;
    rmn_pkg::div_rsp_t div_rsp;

    rmn_ram #(
        .WIDTH (DW),
        .DEPTH (rmn_pkg::MAX_COLS)
    ) u_row_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (sample),
        .raddr (k_reg),
        .rdata (ram_rdata)
    );

    rmn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign busy   = (state_reg != rmn_pkg::S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        if (row_length_reg == '0)
        begin
            len = LW'(1);
        end
        else if (row_length_reg > LW'(rmn_pkg::MAX_COLS))
        begin
            len = LW'(rmn_pkg::MAX_COLS);
        end
        else
        begin
            len = row_length_reg;
        end
    end

    assign sample_mag = rmn_pkg::magnitude(sample);
    assign in_max     = (col_reg >= max_first_reg) && (col_reg <= max_last_reg);
    assign peak_upd   = (in_max && (sample_mag > peak_reg)) ? sample_mag : peak_reg;
    assign count_now  = {1'b0, col_reg} + 1'b1;
    assign in_norm    = (k_reg >= norm_first_reg) && (k_reg <= norm_last_reg);
    assign last_k     = (({1'b0, k_reg} + 1'b1) == count_reg);

    assign lim     = neg_reg ? QW'({1'b1, {(DW-1){1'b0}}}) : QW'({1'b0, {(DW-1){1'b1}}});
    assign sat_mag = (div_rsp.quotient > lim) ? lim[DW-1:0] : div_rsp.quotient[DW-1:0];

    assign div_req = {div_start, rmn_pkg::magnitude(ram_rdata), peak_reg};

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        k_next          = k_reg;
        count_next      = count_reg;
        peak_next       = peak_reg;
        row_cnt_next    = row_cnt_reg;
        zero_next       = zero_reg;
        last_row_next   = last_row_reg;
        neg_next        = neg_reg;
        valid_next      = 1'b0;
        scaled_next     = scaled_reg;
        column_next     = column_reg;
        row_end_next    = row_end_reg;
        matrix_end_next = matrix_end_reg;
        zero_out_next   = zero_out_reg;
        div_start       = 1'b0;
        emit            = 1'b0;
        emit_value      = ram_rdata;

        unique case (state_reg)
            rmn_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    peak_next = peak_upd;
                    if (count_now >= len)
                    begin
                        count_next    = count_now;
                        zero_next     = (peak_upd == '0);
                        last_row_next = (row_cnt_reg == (row_count_reg - 1'b1));
                        k_next        = '0;
                        state_next    = rmn_pkg::S_READ;
                    end
                    else
                    begin
                        col_next = count_now[CW-1:0];
                    end
                end
            end
            rmn_pkg::S_READ:
            begin
                state_next = rmn_pkg::S_LOAD;
            end
            rmn_pkg::S_LOAD:
            begin
                if (in_norm && !zero_reg)
                begin
                    div_start  = 1'b1;
                    neg_next   = ram_rdata[DW-1];
                    state_next = rmn_pkg::S_DIV;
                end
                else
                begin
                    emit       = 1'b1;
                    emit_value = in_norm ? '0 : ram_rdata;
                end
            end
            rmn_pkg::S_DIV:
            begin
                if (div_rsp.done)
                begin
                    emit       = 1'b1;
                    emit_value = neg_reg ? (~sat_mag + 1'b1) : sat_mag;
                end
            end
            default:
            begin
                state_next = rmn_pkg::S_IDLE;
            end
        endcase

        if (emit)
        begin
            valid_next      = 1'b1;
            scaled_next     = emit_value;
            column_next     = k_reg;
            row_end_next    = last_k;
            matrix_end_next = last_k && last_row_reg;
            zero_out_next   = zero_reg;
            if (last_k)
            begin
                state_next   = rmn_pkg::S_IDLE;
                col_next     = '0;
                peak_next    = '0;
                row_cnt_next = last_row_reg ? '0 : (row_cnt_reg + 1'b1);
            end
            else
            begin
                k_next     = k_reg + 1'b1;
                state_next = rmn_pkg::S_READ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= LW'(rmn_pkg::MAX_COLS);
            row_count_reg  <= RW'(1);
            max_first_reg  <= '0;
            max_last_reg   <= '1;
            norm_first_reg <= '0;
            norm_last_reg  <= '1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rmn_pkg::REG_ROW_LENGTH:     row_length_reg <= cfg_data[LW-1:0];
                rmn_pkg::REG_ROW_COUNT:      row_count_reg  <= cfg_data[RW-1:0];
                rmn_pkg::REG_MAX_FIRST_COL:  max_first_reg  <= cfg_data[CW-1:0];
                rmn_pkg::REG_MAX_LAST_COL:   max_last_reg   <= cfg_data[CW-1:0];
                rmn_pkg::REG_NORM_FIRST_COL: norm_first_reg <= cfg_data[CW-1:0];
                rmn_pkg::REG_NORM_LAST_COL:  norm_last_reg  <= cfg_data[CW-1:0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rmn_pkg::S_IDLE;
            col_reg      <= '0;
            k_reg        <= '0;
            count_reg    <= '0;
            peak_reg     <= '0;
            row_cnt_reg  <= '0;
            zero_reg     <= 1'b0;
            last_row_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            k_reg        <= k_next;
            count_reg    <= count_next;
            peak_reg     <= peak_next;
            row_cnt_reg  <= row_cnt_next;
            zero_reg     <= zero_next;
            last_row_reg <= last_row_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg        <= neg_next;
        scaled_reg     <= scaled_next;
        column_reg     <= column_next;
        row_end_reg    <= row_end_next;
        matrix_end_reg <= matrix_end_next;
        zero_out_reg   <= zero_out_next;
    end

    assign result_valid = valid_reg;
    assign scaled       = scaled_reg;
    assign column       = column_reg;
    assign row_end      = row_end_reg;
    assign matrix_end   = matrix_end_reg;
    assign zero_max     = zero_out_reg;

    a_matrix_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && matrix_end) |-> row_end)
        else $error("matrix_end without row_end");

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result words on consecutive cycles");

    a_accept_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !result_valid)
        else $error("result word right after a sample");

    a_row_end_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && row_end) |-> !busy)
        else $error("busy after last word of row");

endmodule

FILE: test/row_maxabs_normalize_top_tb.sv
`timescale 1ns / 100ps

module row_maxabs_normalize_top_tb;

    localparam int DATA_WIDTH = rmn_pkg::DATA_WIDTH;
    localparam int COL_W      = rmn_pkg::COL_W;
    localparam int LEN_W      = rmn_pkg::LEN_W;
    localparam int ROWS_W     = rmn_pkg::ROWS_W;
    localparam int MAX_COLS   = rmn_pkg::MAX_COLS;
    localparam int CFG_IDX_W  = rmn_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = rmn_pkg::CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_HOLE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE_HI = 3'd7;

    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_N          = 52;

    typedef enum logic {
        DIR_WRITE,
        DIR_SAMPLE
    } dir_op_t;

    typedef struct packed {
        dir_op_t                op;
        logic [CFG_IDX_W-1:0]   idx;
        logic [DATA_WIDTH-1:0]  value;
        logic                   typed;
        logic [DATA_WIDTH-1:0]  exp_scaled;
        logic                   exp_zero;
    } step_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]  scaled;
        logic [COL_W-1:0]       column;
        logic                   row_end;
        logic                   matrix_end;
        logic                   zero_max;
    } elem_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic signed [DATA_WIDTH-1:0] sample;
    logic                         cfg_write;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    logic                         result_valid;
    logic signed [DATA_WIDTH-1:0] scaled;
    logic [COL_W-1:0]             column;
    logic                         row_end;
    logic                         matrix_end;
    logic                         zero_max;

    // shadow registers and row state
    logic [LEN_W-1:0]      row_len_reg;
    logic [ROWS_W-1:0]     row_cnt_reg;
    logic [COL_W-1:0]      peak_lo;
    logic [COL_W-1:0]      peak_hi;
    logic [COL_W-1:0]      norm_lo;
    logic [COL_W-1:0]      norm_hi;
    logic [DATA_WIDTH-1:0] row_buf [MAX_COLS];
    logic [DATA_WIDTH-1:0] peak;
    int                    fill;
    logic [ROWS_W-1:0]     row_idx;

    elem_t row_words [MAX_COLS];
    elem_t pending_words [$];

    int err_count;
    int samples_sent;
    int words_seen;
    int rows_seen;
    int zero_rows;
    int reg_writes;

    step_t dir_steps [DIR_N] = '{
        '{DIR_WRITE,  rmn_pkg::REG_ROW_LENGTH,     32'd1,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_ROW_COUNT,      32'd1,         1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h0001_0000, 1'b1, 32'h0001_0000, 1'b0},
        '{DIR_SAMPLE, '0,                          32'h8000_0000, 1'b1, 32'hFFFF_0000, 1'b0},
        '{DIR_SAMPLE, '0,                          32'h7FFF_FFFF, 1'b1, 32'h0001_0000, 1'b0},
        '{DIR_SAMPLE, '0,                          32'hFFFF_FFFF, 1'b1, 32'hFFFF_0000, 1'b0},
        '{DIR_SAMPLE, '0,                          32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
        '{DIR_WRITE,  rmn_pkg::REG_ROW_LENGTH,     32'd0,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_NORM_FIRST_COL, 32'd3,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_NORM_LAST_COL,  32'd0,         1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h1234_5678, 1'b1, 32'h1234_5678, 1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_MAX_FIRST_COL,  32'd1,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_MAX_LAST_COL,   32'd0,         1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1},
        '{DIR_WRITE,  rmn_pkg::REG_ROW_LENGTH,     32'd4,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_ROW_COUNT,      32'd2,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_MAX_FIRST_COL,  32'd0,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_MAX_LAST_COL,   32'd63,        1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_NORM_FIRST_COL, 32'd0,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_NORM_LAST_COL,  32'd63,        1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h8000_0000, 1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h0000_0001, 1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_MAX_LAST_COL,   32'd1,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_NORM_FIRST_COL, 32'd1,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_NORM_LAST_COL,  32'd3,         1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h0000_0100, 1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'hFFFF_FF00, 1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h8000_0000, 1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_MAX_FIRST_COL,  32'd3,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_MAX_LAST_COL,   32'd2,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_NORM_LAST_COL,  32'd2,         1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h0005_0000, 1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'hFFFB_0000, 1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h0000_0000, 1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h0003_0000, 1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_MAX_FIRST_COL,  32'd0,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_MAX_LAST_COL,   32'd63,        1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_NORM_FIRST_COL, 32'd0,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_NORM_LAST_COL,  32'd63,        1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_ROW_LENGTH,     32'd6,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  REG_HOLE_LO,                 32'hFFFF,      1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  REG_HOLE_HI,                 32'h0001,      1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h0002_0000, 1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'hFFFE_8000, 1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h0001_8000, 1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h0000_1000, 1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_ROW_LENGTH,     32'd2,         1'b0, 32'h0,         1'b0},
        '{DIR_WRITE,  rmn_pkg::REG_MAX_FIRST_COL,  32'd2,         1'b0, 32'h0,         1'b0},
        '{DIR_SAMPLE, '0,                          32'h0000_C000, 1'b0, 32'h0,         1'b0}
    };

    row_maxabs_normalize_top u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endfunction

    function automatic void queue_word(input elem_t w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    task automatic absorb_sample(input logic [DATA_WIDTH-1:0] s, output int n);
        int                    len;
        int                    k;
        logic [DATA_WIDTH-1:0] mag;
        logic [DATA_WIDTH-1:0] v;
        logic [63:0]           quot;
        logic [63:0]           lim;
        logic                  last_row;
        logic                  zero_peak;
        len = int'(row_len_reg);
        if (len < 1)
        begin
            len = 1;
        end
        if (len > MAX_COLS)
        begin
            len = MAX_COLS;
        end
        row_buf[fill] = s;
        mag = s[DATA_WIDTH-1] ? -s : s;
        if (fill >= peak_lo && fill <= peak_hi && mag > peak)
        begin
            peak = mag;
        end
        fill++;
        n = 0;
        if (fill < len)
        begin
            return;
        end
        zero_peak = (peak == '0);
        last_row  = (row_idx == row_cnt_reg - 16'd1);
        for (k = 0; k < fill; k++)
        begin
            v = row_buf[k];
            if (k >= norm_lo && k <= norm_hi)
            begin
                if (zero_peak)
                begin
                    v = '0;
                end
                else
                begin
                    // truncate toward zero, then saturate
                    mag  = v[DATA_WIDTH-1] ? -v : v;
                    quot = {16'h0, mag, 16'h0} / {32'h0, peak};
                    lim  = v[DATA_WIDTH-1] ? 64'h8000_0000 : 64'h7FFF_FFFF;
                    if (quot > lim)
                    begin
                        quot = lim;
                    end
                    v = v[DATA_WIDTH-1] ? -quot[DATA_WIDTH-1:0] : quot[DATA_WIDTH-1:0];
                end
            end
            row_words[k] = '{v, COL_W'(k), k == fill - 1, k == fill - 1 && last_row,
                             zero_peak};
        end
        n = fill;
        fill = 0;
        peak = '0;
        row_idx = last_row ? '0 : row_idx + 16'd1;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        unique case (idx)
            rmn_pkg::REG_ROW_LENGTH:     row_len_reg = val[LEN_W-1:0];
            rmn_pkg::REG_ROW_COUNT:      row_cnt_reg = val[ROWS_W-1:0];
            rmn_pkg::REG_MAX_FIRST_COL:  peak_lo     = val[COL_W-1:0];
            rmn_pkg::REG_MAX_LAST_COL:   peak_hi     = val[COL_W-1:0];
            rmn_pkg::REG_NORM_FIRST_COL: norm_lo     = val[COL_W-1:0];
            rmn_pkg::REG_NORM_LAST_COL:  norm_hi     = val[COL_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic send_word(input logic [DATA_WIDTH-1:0] v, input int gap_pct,
                             input logic typed, input elem_t typed_word);
        int n;
        int k;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start  <= 1'b1;
        sample <= v;
        @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        samples_sent++;
        absorb_sample(v, n);
        if (typed)
        begin
            queue_word(typed_word);
        end
        else
        begin
            for (k = 0; k < n; k++)
            begin
                queue_word(row_words[k]);
            end
        end
    endtask

    always @(negedge clk)
    begin
        elem_t got;
        elem_t want;
        if (rst_n && result_valid)
        begin
            got = '{scaled, column, row_end, matrix_end, zero_max};
            words_seen++;
            if (got.row_end)
            begin
                rows_seen++;
                if (got.zero_max)
                begin
                    zero_rows++;
                end
            end
            if (pending_words.size() == 0)
            begin
                note_error($sformatf("unexpected word: scaled %h col %0d end %b/%b zero %b",
                                     got.scaled, got.column, got.row_end, got.matrix_end,
                                     got.zero_max));
            end
            else
            begin
                want = pending_words.pop_front();
                if (got.scaled !== want.scaled || got.column !== want.column ||
                    got.row_end !== want.row_end || got.matrix_end !== want.matrix_end ||
                    got.zero_max !== want.zero_max)
                begin
                    note_error($sformatf({"word %0d: expected scaled %h col %0d end %b/%b ",
                                          "zero %b, got scaled %h col %0d end %b/%b zero %b"},
                                         words_seen, want.scaled, want.column, want.row_end,
                                         want.matrix_end, want.zero_max, got.scaled,
                                         got.column, got.row_end, got.matrix_end,
                                         got.zero_max));
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((start && !busy) || result_valid)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int                    i;
        int                    ph;
        int                    j;
        int                    items;
        int                    idle_pct;
        step_t                 st;
        logic [CFG_DATA_W-1:0] rl;
        logic [CFG_DATA_W-1:0] rc;
        logic [COL_W-1:0]      mf;
        logic [COL_W-1:0]      ml;
        logic [COL_W-1:0]      nf;
        logic [COL_W-1:0]      nl;
        logic [COL_W-1:0]      tmp;
        logic [DATA_WIDTH-1:0] v;

        rst_n     = 1'b0;
        start     = 1'b0;
        sample    = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        row_len_reg = LEN_W'(MAX_COLS);
        row_cnt_reg = 16'd1;
        peak_lo     = '0;
        peak_hi     = COL_W'(MAX_COLS - 1);
        norm_lo     = '0;
        norm_hi     = COL_W'(MAX_COLS - 1);
        peak        = '0;
        fill        = 0;
        row_idx     = '0;

        err_count    = 0;
        samples_sent = 0;
        words_seen   = 0;
        rows_seen    = 0;
        zero_rows    = 0;
        reg_writes   = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_N; i++)
        begin
            st = dir_steps[i];
            if (st.op == DIR_WRITE)
            begin
                write_reg(st.idx, st.value[CFG_DATA_W-1:0]);
            end
            else
            begin
                send_word(st.value, 0, st.typed,
                          '{st.exp_scaled, COL_W'(0), 1'b1, 1'b1, st.exp_zero});
            end
        end

        for (ph = 0; ph < 9; ph++)
        begin
            idle_pct = (ph < 3) ? 28 : ((ph < 6) ? 57 : 0);
            items = 37;
            case (ph)
                0:
                begin
                    rl = 16'd127;
                    rc = 16'd0;
                    mf = '0;
                    ml = 6'd63;
                    nf = '0;
                    nl = 6'd63;
                    items = MAX_COLS;
                end
                8:
                begin
                    rl = 16'd64;
                    rc = 16'hFFFF;
                    mf = 6'd63;
                    ml = 6'd63;
                    nf = '0;
                    nl = 6'd63;
                    items = MAX_COLS;
                end
                default:
                begin
                    rl = 16'($urandom_range(1, 12));
                    rc = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                         16'($urandom_range(1, 4));
                    mf = COL_W'($urandom_range(0, rl - 1));
                    ml = COL_W'($urandom_range(0, rl - 1));
                    nf = COL_W'($urandom_range(0, rl - 1));
                    nl = COL_W'($urandom_range(0, rl - 1));
                    // keep most ranges non-empty
                    if (mf > ml && $urandom_range(0, 3) != 0)
                    begin
                        tmp = mf;
                        mf = ml;
                        ml = tmp;
                    end
                    if (nf > nl && $urandom_range(0, 3) != 0)
                    begin
                        tmp = nf;
                        nf = nl;
                        nl = tmp;
                    end
                end
            endcase
            write_reg(rmn_pkg::REG_ROW_LENGTH, rl);
            write_reg(rmn_pkg::REG_ROW_COUNT, rc);
            write_reg(rmn_pkg::REG_MAX_FIRST_COL, CFG_DATA_W'(mf));
            write_reg(rmn_pkg::REG_MAX_LAST_COL, CFG_DATA_W'(ml));
            write_reg(rmn_pkg::REG_NORM_FIRST_COL, CFG_DATA_W'(nf));
            write_reg(rmn_pkg::REG_NORM_LAST_COL, CFG_DATA_W'(nl));

            for (j = 0; j < items; j++)
            begin
                // hold off until the block has drained
                if ((ph == 2 && j == 20) || $urandom_range(0, 99) == 0)
                begin
                    wait_drained();
                end
                case ($urandom_range(0, 9))
                    0:       v = '0;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h7FFF_FFFF;
                    3:       v = 32'h0000_0001;
                    4, 5:    v = 32'($urandom_range(0, 32'h0003_FFFF));
                    default: v = $urandom >> $urandom_range(0, 24);
                endcase
                if ($urandom_range(0, 1))
                begin
                    v = -v;
                end
                send_word(v, idle_pct, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d samples, %0d result words in %0d rows (%0d zero-peak rows)",
                 samples_sent, words_seen, rows_seen, zero_rows);
        $display("%0d register writes, row lengths 0 to 127, sender gaps at 28%%, 57%% and none",
                 reg_writes);
        if (err_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("%0d mismatches in total", err_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
